[design/gbn_pkg.sv]
package gbn_pkg;

  // Fixed field widths of the channels
  localparam int REQ_W      = 2;
  localparam int ACK_W      = 16;
  localparam int SEQ_OUT_W  = 16;
  localparam int COUNT_W    = 32;
  localparam int TOTAL_W    = 16;
  localparam int WINDOW_W   = 6;
  localparam int LOSS_W     = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Parameter defaults
  localparam int DEF_MAX_WINDOW = 32;
  localparam int DEF_SEQ_WIDTH  = 16;

  // Register reset values
  localparam logic [TOTAL_W-1:0]  RESET_FRAME_TOTAL = 16'd1;
  localparam logic [WINDOW_W-1:0] RESET_WINDOW      = 6'd4;
  localparam logic [LOSS_W-1:0]   RESET_LOSS_FRAME  = 16'd0;

  typedef enum logic [REQ_W-1:0] {
    REQ_START   = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TIMEOUT = 2'd2
  } req_kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FRAME_TOTAL  = 2'd0,
    CFG_WINDOW_LIMIT = 2'd1,
    CFG_LOSS_FRAME   = 2'd2
  } cfg_addr_t;

  // Controller -> datapath
  typedef struct packed {
    logic start;
    logic ack;
    logic timeout;
    logic emit_frame;
    logic emit_end;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic finished;
    logic all_acked;
    logic can_send;
    logic send_last;
    logic slot_free;
  } dp_stat_t;

endpackage

[design/gbn_if.sv]
interface gbn_req_if;
  logic                         valid;
  logic                         ready;
  logic [gbn_pkg::REQ_W-1:0]    req_type;
  logic [gbn_pkg::ACK_W-1:0]    ack_num;

  modport source (output valid, output req_type, output ack_num, input ready);
  modport sink   (input valid, input req_type, input ack_num, output ready);
endinterface

interface gbn_frm_if;
  logic                          valid;
  logic                          ready;
  logic [gbn_pkg::SEQ_OUT_W-1:0] seq_num;
  logic                          drop_mark;
  logic                          eot_mark;
  logic [gbn_pkg::COUNT_W-1:0]   sent_count;
  logic                          last;

  modport source (output valid, output seq_num, output drop_mark, output eot_mark,
                  output sent_count, output last, input ready);
  modport sink   (input valid, input seq_num, input drop_mark, input eot_mark,
                  input sent_count, input last, output ready);
endinterface

interface gbn_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gbn_pkg::CFG_ADDR_W-1:0] addr;
  logic [gbn_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

[design/go_back_n_sender.sv]
// Go-Back-N sender window engine.
// An event updates state when accepted; its frames then leave the output register.
// Throughput: one frame per cycle while the output slot is free; an event holds the
//   request channel through its burst (at most MAX_WINDOW frames) or end frame;
//   empty bursts and ignored events free it sooner; output stalls hold it longer.
// Reset (rst, synchronous, active high): registers to defaults, base = next = 1.
module go_back_n_sender #(
  parameter int MAX_WINDOW = gbn_pkg::DEF_MAX_WINDOW,
  parameter int SEQ_WIDTH  = gbn_pkg::DEF_SEQ_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  gbn_req_if.sink   req,   // events: start, cumulative ack, timeout
  gbn_frm_if.source frm,   // transmitted frames and the end frame
  gbn_cfg_if.sink   cfg    // register writes
);

  // Controller/datapath split:
  //  - gbn_ctrl takes the event transfer, issues one state-update command,
  //    then walks the burst one frame per cycle while the output slot is free.
  //  - gbn_dp holds the config registers, window state, transmission counter
  //    and the output register, and reports window status back.
  gbn_pkg::dp_cmd_t  cmd;
  gbn_pkg::dp_stat_t stat;

  gbn_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat),
    .cmd  (cmd)
  );

  // ack value goes straight to the datapath; the controller owns the handshake
  gbn_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_WIDTH  (SEQ_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ack_num (req.ack_num),
    .cfg     (cfg),
    .frm     (frm),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

[design/gbn_ctrl.sv]
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst,
  gbn_req_if.sink           req,
  input  gbn_pkg::dp_stat_t stat,
  output gbn_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BURST = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   req_fire;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (req.req_type == gbn_pkg::REQ_START) begin
            cmd.start  = 1'b1;
            state_next = ST_BURST;
          end else if (!stat.finished && req.req_type == gbn_pkg::REQ_ACK) begin
            cmd.ack    = 1'b1;
            state_next = ST_BURST;
          end else if (!stat.finished && req.req_type == gbn_pkg::REQ_TIMEOUT) begin
            cmd.timeout = 1'b1;
            state_next  = ST_BURST;
          end
        end
      end
      ST_BURST: begin
        if (stat.all_acked) begin
          if (stat.slot_free) begin
            cmd.emit_end = 1'b1;
            state_next   = ST_IDLE;
          end
        end else if (stat.can_send) begin
          if (stat.slot_free) begin
            cmd.emit_frame = 1'b1;
            if (stat.send_last) state_next = ST_IDLE;
          end
        end else begin
          // nothing the window allows: empty burst
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_end_closes_burst: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_end |=> state == ST_IDLE)
    else $error("end frame did not close the burst");

  a_last_closes_burst: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_frame && stat.send_last) |=> state == ST_IDLE)
    else $error("last frame did not close the burst");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.ack, cmd.timeout, cmd.emit_frame, cmd.emit_end}))
    else $error("more than one datapath command");

endmodule

[design/gbn_dp.sv]
module gbn_dp #(
  parameter int MAX_WINDOW = gbn_pkg::DEF_MAX_WINDOW,
  parameter int SEQ_WIDTH  = gbn_pkg::DEF_SEQ_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [gbn_pkg::ACK_W-1:0]   ack_num,
  gbn_cfg_if.sink                     cfg,
  gbn_frm_if.source                   frm,
  input  gbn_pkg::dp_cmd_t            cmd,
  output gbn_pkg::dp_stat_t           stat
);

  // compare width: covers sequence numbers, 16-bit fields and base + window
  localparam int CW = ((SEQ_WIDTH > gbn_pkg::ACK_W) ? SEQ_WIDTH : gbn_pkg::ACK_W) + 1;

  logic [gbn_pkg::TOTAL_W-1:0]  frame_total;
  logic [gbn_pkg::WINDOW_W-1:0] window_limit;
  logic [gbn_pkg::LOSS_W-1:0]   loss_frame;

  logic [SEQ_WIDTH-1:0]         base;
  logic [SEQ_WIDTH-1:0]         next;
  logic                         loss_used;
  logic [gbn_pkg::LOSS_W-1:0]   loss_target;
  logic [gbn_pkg::COUNT_W-1:0]  trans;
  logic                         finished;
  logic                         out_valid;

  logic [CW-1:0] cap_c, total_raw, total_c, win_raw, win_c;
  logic [CW-1:0] base_c, next_c, next1_c, limit_c, ack_c, ack_cl, loss_c;
  logic [gbn_pkg::COUNT_W-1:0] trans_inc;
  logic drop_now;

  assign cap_c     = (CW'(1) << SEQ_WIDTH) - CW'(2);
  assign total_raw = CW'(frame_total);
  assign total_c   = (total_raw > cap_c) ? cap_c : total_raw;
  assign win_raw   = CW'(window_limit);
  assign win_c     = (win_raw == '0) ? CW'(1) :
                     ((win_raw > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : win_raw);

  assign base_c  = CW'(base);
  assign next_c  = CW'(next);
  assign next1_c = next_c + CW'(1);
  assign limit_c = base_c + win_c;
  assign ack_c   = CW'(ack_num);
  assign ack_cl  = (ack_c > next_c) ? next_c : ack_c;
  assign loss_c  = CW'(loss_target);

  assign drop_now  = (loss_target != '0) && (loss_c == next_c) && !loss_used;
  assign trans_inc = (trans == '1) ? trans : trans + gbn_pkg::COUNT_W'(1);

  assign stat.finished  = finished;
  assign stat.all_acked = base_c > total_c;
  assign stat.can_send  = (next_c < limit_c) && (next_c <= total_c);
  assign stat.send_last = !((next1_c < limit_c) && (next1_c <= total_c));
  assign stat.slot_free = !out_valid || frm.ready;

  assign cfg.ready = 1'b1;
  assign frm.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_total  <= gbn_pkg::RESET_FRAME_TOTAL;
      window_limit <= gbn_pkg::RESET_WINDOW;
      loss_frame   <= gbn_pkg::RESET_LOSS_FRAME;
      base         <= SEQ_WIDTH'(1);
      next         <= SEQ_WIDTH'(1);
      loss_used    <= 1'b0;
      loss_target  <= '0;
      trans        <= '0;
      finished     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.addr)
          gbn_pkg::CFG_FRAME_TOTAL:  frame_total  <= cfg.data[gbn_pkg::TOTAL_W-1:0];
          gbn_pkg::CFG_WINDOW_LIMIT: window_limit <= cfg.data[gbn_pkg::WINDOW_W-1:0];
          gbn_pkg::CFG_LOSS_FRAME:   loss_frame   <= cfg.data[gbn_pkg::LOSS_W-1:0];
          default: ;
        endcase
      end

      if (cmd.start) begin
        base        <= SEQ_WIDTH'(1);
        next        <= SEQ_WIDTH'(1);
        loss_used   <= 1'b0;
        loss_target <= loss_frame;
        trans       <= '0;
        finished    <= 1'b0;
      end else if (cmd.ack) begin
        if (ack_cl > base_c) base <= SEQ_WIDTH'(ack_cl);
      end else if (cmd.timeout) begin
        next <= base;
        if (loss_c == base_c) loss_target <= '0;
      end else if (cmd.emit_frame) begin
        next  <= next + SEQ_WIDTH'(1);
        trans <= trans_inc;
        if (drop_now) loss_used <= 1'b1;
      end else if (cmd.emit_end) begin
        finished <= 1'b1;
      end

      if (cmd.emit_frame || cmd.emit_end) begin
        out_valid <= 1'b1;
      end else if (frm.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (cmd.emit_frame) begin
      frm.seq_num    <= gbn_pkg::SEQ_OUT_W'(next_c);
      frm.drop_mark  <= drop_now;
      frm.eot_mark   <= 1'b0;
      frm.sent_count <= trans_inc;
      frm.last       <= stat.send_last;
    end else if (cmd.emit_end) begin
      frm.seq_num    <= '0;
      frm.drop_mark  <= 1'b0;
      frm.eot_mark   <= 1'b1;
      frm.sent_count <= trans;
      frm.last       <= 1'b1;
    end
  end

  a_next_not_below_base: assert property (@(posedge clk) disable iff (rst)
    next_c >= base_c)
    else $error("next sequence number fell below window base");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_frame || cmd.emit_end) |-> stat.slot_free)
    else $error("emit while output register is occupied");

  a_frame_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_frame |-> (stat.can_send && !stat.all_acked))
    else $error("frame emitted outside the window");

  a_end_sets_finished: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_end |=> finished)
    else $error("end frame did not mark the run finished");

endmodule
